/* hdl/sorted_priority_queue_defines.svh */
// Assertion macros for the sorted priority queue.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sorted_priority_queue: assertion failed");
`define SPQ_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

/* hdl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  // Fixed field widths.
  localparam int unsigned DataW      = 32;
  localparam int unsigned CountOutW  = 5;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 40;
  localparam int unsigned CapacityDef = 16;

  // Request kinds carried in tuser.
  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_PEEK   = 2'd3
  } spq_req_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_FULL_DROP = 2'd2
  } spq_status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             insert_en;
    logic             pop_en;
    logic [DataW-1:0] value;
  } spq_cmd_t;

endpackage

`default_nettype wire

/* hdl/spq_cell.sv */
`default_nettype none

// One slot of the sorted chain. On an insert it keeps its value, takes the new
// value or takes its upper neighbor's value; on a pop it takes its lower neighbor's.
module spq_cell (
  input  wire logic                        clk_i,
  input  wire spq_pkg::spq_cmd_t           cmd_i,
  input  wire logic                        occ_i,
  input  wire logic                        prev_ge_i,
  input  wire logic [spq_pkg::DataW-1:0]   prev_value_i,
  input  wire logic [spq_pkg::DataW-1:0]   next_value_i,
  output logic [spq_pkg::DataW-1:0]        value_o,
  output logic                             ge_o
);

  logic [spq_pkg::DataW-1:0] value_q;
  logic [spq_pkg::DataW-1:0] value_d;

  // This slot holds a value at least as large as the one being inserted.
  assign ge_o = occ_i && ($signed(value_q) >= $signed(cmd_i.value));

  // Next slot value.
  always_comb begin
    value_d = value_q;
    if (cmd_i.insert_en) begin
      if (ge_o) begin
        value_d = value_q;
      end else if (prev_ge_i) begin
        value_d = cmd_i.value;
      end else begin
        value_d = prev_value_i;
      end
    end else if (cmd_i.pop_en) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

/* hdl/sorted_priority_queue.sv */
`default_nettype none

// Bounded priority queue of signed 32-bit values, largest first; equal values
// leave in arrival order. The values sit in a chain of CAPACITY cells that all
// update together on each accepted request (insert, pop, clear or peek), and one
// beat may be accepted in every cycle while the result side keeps up. Each request
// yields one result beat, registered in the cycle after the input
// beat: the head value (0 when empty), an empty flag, the low five bits of the
// count and a status. An insert into a full queue is dropped with status 2; a pop
// of an empty queue changes nothing and returns status 1. No clearing pass is
// needed after reset.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CapacityDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: value[31:0]
  input  wire logic [spq_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [spq_pkg::ReqW-1:0]      s_axis_tuser,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: head_value[31:0], is_empty[32], entry_count[37:33], status[39:38]
  output logic [spq_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]           count_q, count_d;
  logic                      out_valid_q;
  logic                      out_empty_q;
  logic [CntW-1:0]           out_count_q;
  spq_pkg::spq_status_e      out_status_q, status_d;
  logic                      in_acc;
  logic                      full, empty;
  logic                      ins_en, pop_en;
  spq_pkg::spq_req_e         req;
  spq_pkg::spq_cmd_t         cmd;
  logic [spq_pkg::DataW-1:0] cell_value [CAPACITY];
  logic                      cell_ge [CAPACITY];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign req           = spq_pkg::spq_req_e'(s_axis_tuser);
  assign full          = (count_q == CntW'(CAPACITY));
  assign empty         = (count_q == '0);

  // Request decode and next count.
  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_OK;
    ins_en   = 1'b0;
    pop_en   = 1'b0;
    case (req)
      spq_pkg::REQ_INSERT: begin
        if (full) begin
          status_d = spq_pkg::ST_FULL_DROP;
        end else begin
          ins_en  = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      spq_pkg::REQ_POP: begin
        if (empty) begin
          status_d = spq_pkg::ST_POP_EMPTY;
        end else begin
          pop_en  = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      spq_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      spq_pkg::REQ_PEEK: begin
        count_d = count_q;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign cmd.insert_en = in_acc && ins_en;
  assign cmd.pop_en    = in_acc && pop_en;
  assign cmd.value     = s_axis_tdata[spq_pkg::DataW-1:0];

  // The chain of cells; cell 0 holds the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      occ;
    logic                      prev_ge;
    logic [spq_pkg::DataW-1:0] prev_value;
    logic [spq_pkg::DataW-1:0] next_value;

    assign occ = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_value = cell_value[i];
    end else begin : g_body
      assign prev_ge    = cell_ge[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ),
      .prev_ge_i    (prev_ge),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .ge_o         (cell_ge[i])
    );
  end

  // Count and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_empty_q  <= 1'b1;
      out_count_q  <= '0;
      out_status_q <= spq_pkg::ST_OK;
    end else if (in_acc) begin
      count_q      <= count_d;
      out_valid_q  <= 1'b1;
      out_empty_q  <= (count_d == '0);
      out_count_q  <= count_d;
      out_status_q <= status_d;
    end else if (m_axis_tready) begin
      out_valid_q  <= 1'b0;
    end
  end

  // The cells change only with an accepted beat, which happens only once the
  // previous result is taken, so the head cell matches the pending result.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_status_q,
                          spq_pkg::CountOutW'(out_count_q),
                          out_empty_q,
                          out_empty_q ? {spq_pkg::DataW{1'b0}} : cell_value[0]};

`include "sorted_priority_queue_defines.svh"

  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY))
  `SPQ_ASSERT_MSG(a_empty_matches, out_empty_q == (count_q == '0), "empty flag off")
  `SPQ_ASSERT(a_pop_dec, cmd.pop_en |=> count_q == $past(count_q) - CntW'(1))
  `SPQ_ASSERT(a_drop_full, out_valid_q && (out_status_q == spq_pkg::ST_FULL_DROP) |-> full)

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Capacity    = spq_pkg::CapacityDef;
  localparam int unsigned HoldAtBeat  = 40;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned MaxReports  = 10;

  // One request waiting to be sent, with the idle cycles that follow it.
  typedef struct {
    spq_pkg::spq_req_e req;
    logic [31:0]       value;
    int unsigned       gap;
  } request_t;

  // What the queue should answer for one request.
  typedef struct {
    logic [31:0]          head;
    logic                 empty;
    logic [4:0]           count;
    spq_pkg::spq_status_e status;
  } answer_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic [spq_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [spq_pkg::ReqW-1:0]     s_axis_tuser  = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [spq_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;

  sorted_priority_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  request_t          pending_requests[$];
  answer_t           expected_answers[$];
  logic signed [31:0] queued_values[$];
  int unsigned       total_requests = 0;
  int unsigned       in_beats       = 0;
  int unsigned       mismatch_count = 0;
  logic              in_taken       = 1'b0;
  int unsigned       send_gap_left  = 0;
  int unsigned       stall_left     = 0;
  int unsigned       hold_left      = 0;
  bit                hold_done      = 1'b0;

  // Clock and a single reset pulse.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values: wide random, a narrow band that gives many ties, or the extremes.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 15)) - 8);
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic void add_request(spq_pkg::spq_req_e req, logic [31:0] value,
                                      int unsigned gap);
    request_t item;
    item.req   = req;
    item.value = value;
    item.gap   = gap;
    pending_requests.push_back(item);
    total_requests++;
  endfunction

  // Sorted-list model: new values go behind every stored value >= them.
  task automatic predict_request(input spq_pkg::spq_req_e req, input logic [31:0] value,
                                 output answer_t ans);
    int pos;
    ans.status = spq_pkg::ST_OK;
    case (req)
      spq_pkg::REQ_INSERT: begin
        if (queued_values.size() >= Capacity) begin
          ans.status = spq_pkg::ST_FULL_DROP;
        end else begin
          pos = 0;
          while (pos < queued_values.size() && queued_values[pos] >= $signed(value))
            pos++;
          queued_values.insert(pos, $signed(value));
        end
      end
      spq_pkg::REQ_POP: begin
        if (queued_values.size() == 0) ans.status = spq_pkg::ST_POP_EMPTY;
        else void'(queued_values.pop_front());
      end
      spq_pkg::REQ_CLEAR: begin
        queued_values.delete();
      end
      default: begin
      end
    endcase
    ans.head  = (queued_values.size() != 0) ? queued_values[0] : 32'd0;
    ans.empty = (queued_values.size() == 0);
    ans.count = 5'(queued_values.size());
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Request list: a directed opening, then random segments.
  initial begin
    int unsigned seg_len;
    int unsigned mode;
    int unsigned r;
    bit calm;
    spq_pkg::spq_req_e req;

    // Empty queue behavior.
    add_request(spq_pkg::REQ_PEEK, 32'hFFFF_FFFF, 0);
    add_request(spq_pkg::REQ_POP, 32'h1234_5678, 0);
    add_request(spq_pkg::REQ_CLEAR, 32'h0, 0);
    // Fill to capacity with extremes and ties.
    add_request(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 0);
    add_request(spq_pkg::REQ_INSERT, 32'h8000_0000, 1);
    add_request(spq_pkg::REQ_INSERT, 32'h0000_0000, 0);
    add_request(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 0);
    add_request(spq_pkg::REQ_INSERT, 32'd5, 2);
    add_request(spq_pkg::REQ_INSERT, 32'd5, 0);
    add_request(spq_pkg::REQ_INSERT, 32'd5, 0);
    add_request(spq_pkg::REQ_INSERT, 32'd1, 0);
    add_request(spq_pkg::REQ_INSERT, 32'hFFFF_FFFB, 0);
    add_request(spq_pkg::REQ_INSERT, 32'h8000_0000, 0);
    add_request(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 0);
    for (int i = 0; i < 5; i++) add_request(spq_pkg::REQ_INSERT, $urandom, 0);
    // Insert into the full queue is dropped.
    add_request(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 0);
    add_request(spq_pkg::REQ_PEEK, 32'h0, 0);
    add_request(spq_pkg::REQ_POP, 32'h0, 0);
    add_request(spq_pkg::REQ_POP, 32'hFFFF_FFFF, 0);
    add_request(spq_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 0);
    add_request(spq_pkg::REQ_POP, 32'h0, 0);

    // The first random segment fills back-to-back while the receiver holds off.
    for (int i = 0; i < 60; i++) add_request(spq_pkg::REQ_INSERT, pick_value(), 0);

    // Segments lean toward filling, draining or a mix.
    while (total_requests < RandomItems + 60) begin
      seg_len = $urandom_range(20, 60);
      mode    = $urandom_range(0, 2);
      calm    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: req = (r < 75) ? spq_pkg::REQ_INSERT : (r < 85) ? spq_pkg::REQ_PEEK :
                   (r < 97) ? spq_pkg::REQ_POP : spq_pkg::REQ_CLEAR;
          1: req = (r < 20) ? spq_pkg::REQ_INSERT : (r < 30) ? spq_pkg::REQ_PEEK :
                   (r < 98) ? spq_pkg::REQ_POP : spq_pkg::REQ_CLEAR;
          default: req = (r < 45) ? spq_pkg::REQ_INSERT : (r < 60) ? spq_pkg::REQ_PEEK :
                         (r < 98) ? spq_pkg::REQ_POP : spq_pkg::REQ_CLEAR;
        endcase
        add_request(req, pick_value(), calm ? 0 : pick_idle());
      end
    end
  end

  // Sender: hold a beat until taken, then idle for its gap or offer the next.
  always @(negedge clk_i) begin
    request_t item;
    logic     valid_next;
    valid_next = s_axis_tvalid && !in_taken;
    if (rst_ni && !valid_next) begin
      if (send_gap_left > 0) begin
        send_gap_left--;
      end else if (pending_requests.size() != 0) begin
        item          = pending_requests.pop_front();
        s_axis_tdata  <= item.value;
        s_axis_tuser  <= item.req;
        send_gap_left = item.gap;
        valid_next    = 1'b1;
      end
    end
    s_axis_tvalid <= valid_next;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  always @(negedge clk_i) begin
    logic ready_next;
    bit   calm_rx;
    calm_rx = ((in_beats / 128) % 3 == 1);
    if (!hold_done && in_beats >= HoldAtBeat) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (!rst_ni) begin
      ready_next = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
      stall_left = calm_rx ? 0 : pick_idle();
    end
    m_axis_tready <= ready_next;
  end

  // Monitor: predict on each input beat, check each output beat.
  always @(posedge clk_i) begin
    answer_t ans;
    answer_t want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(spq_pkg::spq_req_e'(s_axis_tuser), s_axis_tdata, ans);
        expected_answers.push_back(ans);
        in_beats <= in_beats + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected beat", 32'd0, m_axis_tdata[31:0]);
        end else begin
          want = expected_answers.pop_front();
          if (m_axis_tdata[31:0] !== want.head)
            report_mismatch("head_value", want.head, m_axis_tdata[31:0]);
          if (m_axis_tdata[32] !== want.empty)
            report_mismatch("is_empty", 32'(want.empty), 32'(m_axis_tdata[32]));
          if (m_axis_tdata[37:33] !== want.count)
            report_mismatch("entry_count", 32'(want.count), 32'(m_axis_tdata[37:33]));
          if (m_axis_tdata[39:38] !== want.status)
            report_mismatch("status", 32'(want.status), 32'(m_axis_tdata[39:38]));
        end
      end
    end
  end

  // End of run: all beats sent and answered, then a short drain.
  initial begin
    @(posedge rst_ni);
    do @(negedge clk_i);
    while (total_requests == 0 || in_beats != total_requests ||
           expected_answers.size() != 0);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
